// ===== rtl/pairwise_distance_rows_unit_defines.svh =====
// Assertion macros shared by the checker.
`ifndef PAIRWISE_DISTANCE_ROWS_UNIT_DEFINES_SVH
`define PAIRWISE_DISTANCE_ROWS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PDR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pdr_pkg.sv =====
`timescale 1ns / 1ps

package pdr_pkg;

  localparam int COORD_BITS     = 20;
  localparam int MAX_POINTS_DEF = 64;
  localparam int IDX_W          = 6;
  localparam int DIST_W         = 22;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic                         end_of_set;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  column_index;
    logic [DIST_W-1:0] dist_value;
    logic              row_done;
    logic              overflow_flag;
  } out_word_t;

endpackage

// ===== rtl/pairwise_distance_rows_unit.sv =====
`timescale 1ns / 1ps
// Distance rows: point i gives i distance words then its zero diagonal word.
// Each stored point passes through read, diff, 4 multiply steps, 21 root steps
// and emit, shaped by the shared squarer and the bit-serial root loop.
// The input stays stalled until a point's whole row has been sent.
// A dropped point (store full) goes straight to emit for its single overflow word.
// Reset clears the sequencer state, point count and output valid; store contents stay stale.
module pairwise_distance_rows_unit #(
  parameter int MAX_POINTS = pdr_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pdr_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output pdr_pkg::out_word_t out_word
);
  import pdr_pkg::*;

  // Derived sizes
  localparam int ADDR_W    = $clog2(MAX_POINTS);
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int SQ_W      = 2 * COORD_BITS;        // one squared difference
  localparam int SUM_W     = 2 * COORD_BITS + 2;    // sum of three squares
  localparam int ROOT_W    = SUM_W / 2;             // root bits = root steps
  localparam int REM_W     = ROOT_W + 3;            // partial remainder
  localparam int MUL_STEPS = 4;                     // 3 squares + final add
  localparam int STEP_W    = $clog2(ROOT_W);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_DIFF = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

  // Point store: one write port (on accept while not full), one registered read port.
  point_t mem [MAX_POINTS];

  logic [2:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_word_r, out_word_nxt;

  point_t                cur_r, cur_nxt;
  point_t                rd_r;
  logic [IDX_W-1:0]      row_r, row_nxt;
  logic [IDX_W-1:0]      j_r, j_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [COORD_BITS-1:0] dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic [SQ_W-1:0]       prod_r, prod_nxt;
  logic [SUM_W-1:0]      acc_r, acc_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [ROOT_W-1:0]     root_r, root_nxt;

  logic                  in_acc;
  logic                  full;
  logic                  out_free;
  logic [COORD_BITS-1:0] mul_op;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      trial;

  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign in_acc    = in_valid && !in_stall;
  assign full      = count_r >= CNT_W'(MAX_POINTS);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // |a - b| with one guard bit; the magnitude always fits COORD_BITS.
  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    if (d[COORD_BITS]) begin
      d = -d;
    end
    return d[COORD_BITS-1:0];
  endfunction

  // Shared squarer operand
  always_comb begin
    case (step_r)
      STEP_W'(0): mul_op = dx_r;
      STEP_W'(1): mul_op = dy_r;
      default:    mul_op = dz_r;
    endcase
  end

  // One digit-by-digit root step: bring down two bits, try (root<<2)|1.
  assign rem_sh = {rem_r[REM_W-3:0], acc_r[SUM_W-1 -: 2]};
  assign trial  = REM_W'({root_r, 2'b01});

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    cur_nxt       = cur_r;
    row_nxt       = row_r;
    j_nxt         = j_r;
    ovf_nxt       = ovf_r;
    step_nxt      = step_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dz_nxt        = dz_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cur_nxt.x = in_word.coord_x;
          cur_nxt.y = in_word.coord_y;
          cur_nxt.z = in_word.coord_z;
          row_nxt   = IDX_W'(count_r);
          j_nxt     = '0;
          ovf_nxt   = full;
          if (in_word.end_of_set) begin
            count_nxt = '0;
          end else if (!full) begin
            count_nxt = count_r + CNT_W'(1);
          end
          // empty store or dropped point: straight to the single word
          state_nxt = (full || count_r == '0) ? ST_EMIT : ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        dx_nxt    = abs_diff(cur_r.x, rd_r.x);
        dy_nxt    = abs_diff(cur_r.y, rd_r.y);
        dz_nxt    = abs_diff(cur_r.z, rd_r.z);
        step_nxt  = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // squarer output is registered; the sum trails it by one step
        prod_nxt = mul_op * mul_op;
        acc_nxt  = (step_r == '0) ? '0 : acc_r + SUM_W'(prod_r);
        if (step_r == STEP_W'(MUL_STEPS - 1)) begin
          step_nxt  = '0;
          rem_nxt   = '0;
          root_nxt  = '0;
          state_nxt = ST_SQRT;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_SQRT: begin
        acc_nxt = acc_r << 2;
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          state_nxt = ST_EMIT;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (ovf_r) begin
            out_word_nxt = '{row_index: '0, column_index: '0, dist_value: '0,
                             row_done: 1'b1, overflow_flag: 1'b1};
            state_nxt    = ST_IDLE;
          end else if (j_r == row_r) begin
            // diagonal closes the row
            out_word_nxt = '{row_index: row_r, column_index: row_r, dist_value: '0,
                             row_done: 1'b1, overflow_flag: 1'b0};
            state_nxt    = ST_IDLE;
          end else begin
            out_word_nxt = '{row_index: row_r, column_index: j_r,
                             dist_value: DIST_W'(root_r),
                             row_done: 1'b0, overflow_flag: 1'b0};
            j_nxt        = j_r + IDX_W'(1);
            state_nxt    = (j_r + IDX_W'(1) == row_r) ? ST_EMIT : ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    cur_r      <= cur_nxt;
    row_r      <= row_nxt;
    j_r        <= j_nxt;
    ovf_r      <= ovf_nxt;
    step_r     <= step_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    dz_r       <= dz_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
  end

  // Store: new point written at its index on accept while not full, rows read at j
  always_ff @(posedge clk) begin
    if (in_acc && !full) begin
      mem[count_r[ADDR_W-1:0]] <= '{x: in_word.coord_x, y: in_word.coord_y,
                                    z: in_word.coord_z};
    end
    rd_r <= mem[j_r[ADDR_W-1:0]];
  end

endmodule

// ===== rtl/pdr_checker.sv =====
`timescale 1ns / 1ps
`include "pairwise_distance_rows_unit_defines.svh"

module pdr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input pdr_pkg::out_word_t out_word
);
  import pdr_pkg::*;

  logic in_acc;
  logic out_held;
  logic diag_word, diag_ok;
  logic entry_word, entry_ok;
  logic ovf_word, ovf_ok;

  assign in_acc     = in_valid && !in_stall;
  assign out_held   = out_valid && out_stall;
  assign diag_word  = out_valid && out_word.row_done && !out_word.overflow_flag;
  assign diag_ok    = (out_word.column_index == out_word.row_index) &&
                      (out_word.dist_value == '0);
  assign entry_word = out_valid && !out_word.row_done;
  assign entry_ok   = (out_word.column_index < out_word.row_index) &&
                      !out_word.overflow_flag;
  assign ovf_word   = out_valid && out_word.overflow_flag;
  assign ovf_ok     = out_word.row_done && (out_word.row_index == '0) &&
                      (out_word.dist_value == '0);

  // held word stays put
  `PDR_ASSERT_NEXT(a_hold, clk, rst_n, out_held, out_valid && $stable(out_word), "word changed")
  // one point at a time
  `PDR_ASSERT_NEXT(a_busy, clk, rst_n, in_acc, in_stall, "input taken while a row is in flight")
  // a row closes on its own diagonal
  `PDR_ASSERT_NOW(a_diag, clk, rst_n, diag_word, diag_ok, "bad diagonal word")
  // row entries only look back at earlier points
  `PDR_ASSERT_NOW(a_lower, clk, rst_n, entry_word, entry_ok, "entry outside lower triangle")
  // dropped point gives one zero word that closes it
  `PDR_ASSERT_NOW(a_ovf, clk, rst_n, ovf_word, ovf_ok, "malformed overflow word")

endmodule

bind pairwise_distance_rows_unit pdr_checker u_pdr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
